/* rtl/pfsc_pkg.sv */
// Shared types and codes for the PCM/float32 sample converter.
// No dependencies; the converter top level uses it by scoped names.
`timescale 1ns / 1ps

package pfsc_pkg;

    // Device format codes, shared by the decode and encode registers.
    typedef enum logic [3:0] {
        FMT_F32    = 4'd0,
        FMT_F64    = 4'd1,
        FMT_I16    = 4'd2,
        FMT_I24    = 4'd3,
        FMT_I32    = 4'd4,
        FMT_I32_16 = 4'd5,
        FMT_I32_18 = 4'd6,
        FMT_I32_20 = 4'd7,
        FMT_I32_24 = 4'd8
    } t_fmt;

    // Configuration register indexes.
    localparam logic CFG_DECODE_FMT = 1'b0;
    localparam logic CFG_ENCODE_FMT = 1'b1;

    localparam t_fmt FMT_RESET = FMT_I16;

    // Operation codes.
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    // Width of an encoded integer word.
    typedef enum logic [1:0] {
        WID_16,
        WID_24,
        WID_32
    } t_width;

    // Per-item side information that rides along the pipeline.
    typedef struct packed {
        logic        op;
        logic        last;
        logic        dec_int;
        logic [31:0] dec_direct;
        logic        dec_sign;
        logic [4:0]  dec_k;
        logic        enc_int;
        logic [63:0] enc_direct;
        logic        enc_sign;
        logic        enc_i32;
        t_width      enc_wid;
        logic [7:0]  enc_shift;
        logic [4:0]  enc_len;
    } t_side;

endpackage

/* rtl/pcm_float_sample_converter.sv */
// PCM sample converter top level: device word <-> IEEE float32.
// Depends on pfsc_pkg (format codes, side-band struct).
`timescale 1ns / 1ps

// Usage:
//   Input channel : i_in_valid / o_in_stall carry one sample beat (op,
//   device word, float word, last flag). A beat is taken at a rising edge
//   with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall carry one result beat
//   (float_out, encoded_word, last_out), taken when o_out_valid is high
//   and i_out_stall is low.
//   Config port   : i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 decode format, 1 encode format). Write only while idle.
// Pipeline: five register stages from input beat to output beat:
//   unpack, multiply / leading-one search, normalize / round setup,
//   round, final shift and sign.
// Throughput: one beat per cycle. The whole pipe advances together; it
//   holds only when the output register is full and the receiver stalls,
//   and then o_in_stall is raised in the same cycle.
// Reset: synchronous, active low; clears all valid bits and sets both
//   format registers to int16. Payload registers are not reset.
// Stall: a stalled output beat holds its value; nothing is lost or
//   repeated.
module pcm_float_sample_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [63:0] i_device_word,
    input  logic [31:0] i_float_in,
    input  logic        i_last_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_float_out,
    output logic [63:0] o_encoded_word,
    output logic        o_last_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [3:0]  i_cfg_data
);

    // Flush a denormal float32 to a zero of the same sign.
    function automatic logic [31:0] flush_f32(input logic [31:0] b);
        flush_f32 = (b[30:23] == 8'd0) ? {b[31], 31'd0} : b;
    endfunction

    // float64 to float32, round to nearest even, denormals flushed.
    function automatic logic [31:0] f64_to_f32(input logic [63:0] d);
        logic [10:0]        e;
        logic [51:0]        m;
        logic [22:0]        man;
        logic [28:0]        rem;
        logic               up;
        logic [23:0]        man24;
        logic signed [12:0] fe;
        e     = d[62:52];
        m     = d[51:0];
        man   = m[51:29];
        rem   = m[28:0];
        up    = (rem > 29'h1000_0000) || ((rem == 29'h1000_0000) && man[0]);
        man24 = {1'b0, man} + {23'd0, up};
        fe    = $signed({2'b00, e}) - 13'sd896;
        if (man24[23]) begin
            fe = fe + 13'sd1;
        end
        if (e == 11'h7FF) begin
            if (m == 52'd0) begin
                f64_to_f32 = {d[63], 8'hFF, 23'd0};
            end else begin
                f64_to_f32 = {d[63], 8'hFF, 1'b1, m[50:29]};
            end
        end else if (e == 11'd0) begin
            f64_to_f32 = {d[63], 31'd0};
        end else if (fe >= 13'sd255) begin
            f64_to_f32 = {d[63], 8'hFF, 23'd0};
        end else if (fe <= 13'sd0) begin
            f64_to_f32 = {d[63], 31'd0};
        end else begin
            f64_to_f32 = {d[63], fe[7:0], man24[22:0]};
        end
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    pfsc_pkg::t_fmt r_dec_fmt;
    pfsc_pkg::t_fmt r_enc_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_fmt <= pfsc_pkg::FMT_RESET;
            r_enc_fmt <= pfsc_pkg::FMT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pfsc_pkg::CFG_DECODE_FMT) begin
                r_dec_fmt <= pfsc_pkg::t_fmt'(i_cfg_data);
            end
            if (i_cfg_idx == pfsc_pkg::CFG_ENCODE_FMT) begin
                r_enc_fmt <= pfsc_pkg::t_fmt'(i_cfg_data);
            end
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: advance all stages together unless the output
    // register holds a beat the receiver stalls.
    // ---------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic w_adv;
    assign w_adv      = !(r5_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_in_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: unpack. Decode: pick the integer and its magnitude, or
    // convert float formats outright. Encode: flush, clamp to [-1,1],
    // pick the full-scale factor.
    // ---------------------------------------------------------------
    pfsc_pkg::t_side n1_side, r1_side;
    logic [31:0]     n1_mag,  r1_mag;
    logic [23:0]     n1_man,  r1_man;
    logic [31:0]     n1_scale, r1_scale;

    always_comb begin
        logic [31:0] lo;
        logic [31:0] v;
        logic [31:0] b;
        logic [7:0]  e;
        lo = i_device_word[31:0];
        v  = lo;
        b  = flush_f32(i_float_in);
        e  = b[30:23];

        n1_side            = '0;
        n1_side.op         = i_op;
        n1_side.last       = i_last_sample;
        n1_side.enc_wid    = pfsc_pkg::WID_32;
        n1_scale           = 32'd0;

        // Decode side
        case (r_dec_fmt)
            pfsc_pkg::FMT_F32: n1_side.dec_direct = flush_f32(lo);
            pfsc_pkg::FMT_F64: n1_side.dec_direct = f64_to_f32(i_device_word);
            pfsc_pkg::FMT_I16: begin
                v = {{16{lo[15]}}, lo[15:0]};
                n1_side.dec_int = 1'b1;
                n1_side.dec_k   = 5'd15;
            end
            pfsc_pkg::FMT_I24: begin
                v = {{8{lo[23]}}, lo[23:0]};
                n1_side.dec_int = 1'b1;
                n1_side.dec_k   = 5'd23;
            end
            pfsc_pkg::FMT_I32: begin
                n1_side.dec_int = 1'b1;
                n1_side.dec_k   = 5'd31;
            end
            pfsc_pkg::FMT_I32_16: begin
                n1_side.dec_int = 1'b1;
                n1_side.dec_k   = 5'd15;
            end
            pfsc_pkg::FMT_I32_18: begin
                n1_side.dec_int = 1'b1;
                n1_side.dec_k   = 5'd17;
            end
            pfsc_pkg::FMT_I32_20: begin
                n1_side.dec_int = 1'b1;
                n1_side.dec_k   = 5'd19;
            end
            pfsc_pkg::FMT_I32_24: begin
                n1_side.dec_int = 1'b1;
                n1_side.dec_k   = 5'd23;
            end
            default: n1_side.dec_direct = 32'd0;
        endcase
        n1_side.dec_sign = v[31];
        n1_mag           = v[31] ? (~v + 32'd1) : v;

        // Encode side
        n1_side.enc_sign  = b[31];
        n1_side.enc_shift = 8'd150 - e;
        if (e == 8'd0) begin
            n1_man = 24'd0;
        end else if ((e > 8'd127) || ((e == 8'd127) && (b[22:0] != 23'd0))) begin
            // Clamp to magnitude one (infinities too).
            n1_man            = 24'h80_0000;
            n1_side.enc_shift = 8'd23;
        end else begin
            n1_man = {1'b1, b[22:0]};
        end

        case (r_enc_fmt)
            pfsc_pkg::FMT_F32: n1_side.enc_direct = {32'd0, b};
            pfsc_pkg::FMT_F64: begin
                if (e == 8'd0) begin
                    n1_side.enc_direct = {b[31], 63'd0};
                end else if (e == 8'hFF) begin
                    n1_side.enc_direct = {b[31], 11'h7FF, b[22:0], 29'd0};
                end else begin
                    n1_side.enc_direct = {b[31], {3'd0, e} + 11'd896, b[22:0], 29'd0};
                end
            end
            pfsc_pkg::FMT_I16: begin
                n1_scale        = 32'd32767;
                n1_side.enc_len = 5'd15;
                n1_side.enc_wid = pfsc_pkg::WID_16;
                n1_side.enc_int = 1'b1;
            end
            pfsc_pkg::FMT_I24: begin
                n1_scale        = 32'd8388607;
                n1_side.enc_len = 5'd23;
                n1_side.enc_wid = pfsc_pkg::WID_24;
                n1_side.enc_int = 1'b1;
            end
            pfsc_pkg::FMT_I32: begin
                // Exact product by 2^31; no rounding, saturate at the end.
                n1_scale        = 32'h8000_0000;
                n1_side.enc_i32 = 1'b1;
                n1_side.enc_int = 1'b1;
            end
            pfsc_pkg::FMT_I32_16: begin
                n1_scale        = 32'd32767;
                n1_side.enc_len = 5'd15;
                n1_side.enc_int = 1'b1;
            end
            pfsc_pkg::FMT_I32_18: begin
                n1_scale        = 32'd131071;
                n1_side.enc_len = 5'd17;
                n1_side.enc_int = 1'b1;
            end
            pfsc_pkg::FMT_I32_20: begin
                n1_scale        = 32'd524287;
                n1_side.enc_len = 5'd19;
                n1_side.enc_int = 1'b1;
            end
            pfsc_pkg::FMT_I32_24: begin
                n1_scale        = 32'd8388607;
                n1_side.enc_len = 5'd23;
                n1_side.enc_int = 1'b1;
            end
            default: n1_side.enc_direct = 64'd0;
        endcase
        // NaN into an integer format gives zero.
        if ((e == 8'hFF) && (b[22:0] != 23'd0)) begin
            n1_side.enc_int = 1'b0;
            if ((r_enc_fmt != pfsc_pkg::FMT_F32) && (r_enc_fmt != pfsc_pkg::FMT_F64)) begin
                n1_side.enc_direct = 64'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_side  <= n1_side;
            r1_mag   <= n1_mag;
            r1_man   <= n1_man;
            r1_scale <= n1_scale;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: leading-one search on the decode magnitude; exact
    // mantissa times full-scale product for encode.
    // ---------------------------------------------------------------
    pfsc_pkg::t_side r2_side;
    logic [31:0]     r2_mag;
    logic [4:0]      n2_lead, r2_lead;
    logic            r2_zero;
    logic [55:0]     n2_prod, r2_prod;

    always_comb begin
        n2_lead = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (r1_mag[i]) begin
                n2_lead = 5'(i);
            end
        end
        n2_prod = {32'd0, r1_man} * {24'd0, r1_scale};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_side <= r1_side;
            r2_mag  <= r1_mag;
            r2_lead <= n2_lead;
            r2_zero <= (r1_mag == 32'd0);
            r2_prod <= n2_prod;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: normalize the decode magnitude; find the float32 rounding
    // point of the encode product.
    // ---------------------------------------------------------------
    pfsc_pkg::t_side r3_side;
    logic [31:0]     n3_norm, r3_norm;
    logic [4:0]      r3_lead;
    logic            r3_zero;
    logic [55:0]     n3_q, r3_q;
    logic            n3_up, r3_up;
    logic [4:0]      n3_d, r3_d;

    always_comb begin
        logic [5:0]  idx;
        logic [55:0] rem;
        logic [55:0] half;
        n3_norm = r2_mag << (5'd31 - r2_lead);
        idx     = 6'd23 + {1'b0, r2_side.enc_len};
        if (r2_side.enc_i32) begin
            n3_d = 5'd0;
        end else begin
            n3_d = r2_prod[idx] ? r2_side.enc_len : (r2_side.enc_len - 5'd1);
        end
        n3_q = r2_prod >> n3_d;
        rem  = r2_prod & ((56'd1 << n3_d) - 56'd1);
        half = 56'd1 << (n3_d - 5'd1);
        n3_up = !r2_side.enc_i32 && ((rem > half) || ((rem == half) && n3_q[0]));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_side <= r2_side;
            r3_norm <= n3_norm;
            r3_lead <= r2_lead;
            r3_zero <= r2_zero;
            r3_q    <= n3_q;
            r3_up   <= n3_up;
            r3_d    <= n3_d;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: round and pack the decoded float; rebuild the rounded
    // encode product.
    // ---------------------------------------------------------------
    pfsc_pkg::t_side r4_side;
    logic [31:0]     n4_float, r4_float;
    logic [56:0]     n4_round, r4_round;

    always_comb begin
        logic [23:0] mant;
        logic        up;
        logic [24:0] m25;
        logic [8:0]  ex;
        logic [56:0] qs;
        mant = r3_norm[31:8];
        up   = r3_norm[7] && ((r3_norm[6:0] != 7'd0) || mant[0]);
        m25  = {1'b0, mant} + {24'd0, up};
        ex   = {4'd0, r3_lead} + 9'd127 - {4'd0, r3_side.dec_k} + {8'd0, m25[24]};
        if (!r3_side.dec_int) begin
            n4_float = r3_side.dec_direct;
        end else if (r3_zero) begin
            n4_float = 32'd0;
        end else begin
            n4_float = {r3_side.dec_sign, ex[7:0], m25[24] ? 23'd0 : m25[22:0]};
        end
        qs       = {1'b0, r3_q} + {56'd0, r3_up};
        n4_round = qs << r3_d;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_side  <= r3_side;
            r4_float <= n4_float;
            r4_round <= n4_round;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: truncate toward zero, saturate int32, apply sign, mask to
    // the device width; zero the field the op does not use.
    // ---------------------------------------------------------------
    logic [31:0] n5_float, r5_float;
    logic [63:0] n5_enc,   r5_enc;
    logic        r5_last;

    always_comb begin
        logic [56:0] rs;
        logic [31:0] mag;
        logic [31:0] val;
        logic [63:0] word;
        rs  = r4_round >> r4_side.enc_shift;
        mag = rs[31:0];
        val = r4_side.enc_sign ? (~mag + 32'd1) : mag;
        if (r4_side.enc_i32 && !r4_side.enc_sign && mag[31]) begin
            val = 32'h7FFF_FFFF;
        end
        case (r4_side.enc_wid)
            pfsc_pkg::WID_16: word = {48'd0, val[15:0]};
            pfsc_pkg::WID_24: word = {40'd0, val[23:0]};
            default:          word = {32'd0, val};
        endcase
        if (!r4_side.enc_int) begin
            word = r4_side.enc_direct;
        end
        n5_float = (r4_side.op == pfsc_pkg::OP_DECODE) ? r4_float : 32'd0;
        n5_enc   = (r4_side.op == pfsc_pkg::OP_ENCODE) ? word : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_float <= n5_float;
            r5_enc   <= n5_enc;
            r5_last  <= r4_side.last;
        end
    end

    assign o_out_valid    = r5_valid;
    assign o_float_out    = r5_float;
    assign o_encoded_word = r5_enc;
    assign o_last_out     = r5_last;

`ifndef ASSERT_OFF
    // Only one of the two result fields may be nonzero.
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_encoded_word != 64'd0)) |-> (o_float_out == 32'd0))
        else $error("both result fields nonzero");

    // An accepted beat shows up in stage one on the next edge.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r1_valid)
        else $error("accepted beat lost at entry");

    // A beat in stage four reaches the output when the pipe advances.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && w_adv) |=> o_out_valid)
        else $error("beat lost between stage four and output");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking bench for the PCM / float32 sample converter.
// Depends on rtl/pfsc_pkg.sv and rtl/pcm_float_sample_converter.sv.
`timescale 1ns / 1ps

module tb_top;

    localparam int N_PHASES     = 20;
    localparam int BEATS_PHASE  = 100;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic        op;
        logic [63:0] word;
        logic [31:0] fbits;
        logic        last;
    } t_sample;

    typedef struct {
        logic [31:0] fout;
        logic [63:0] enc;
        logic        last;
    } t_conv;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_op;
    logic [63:0] i_device_word;
    logic [31:0] i_float_in;
    logic        i_last_sample;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_float_out;
    logic [63:0] o_encoded_word;
    logic        o_last_out;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [3:0]  i_cfg_data;

    t_sample pending_samples[$];
    t_conv   expected_conv[$];
    logic [3:0] dec_fmt;
    logic [3:0] enc_fmt;
    int src_idle_pct;
    int dst_stall_pct;
    int err_count = 0;
    int beats_checked = 0;

    pcm_float_sample_converter i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor: bit-exact float conversions on plain vectors.
    // ---------------------------------------------------------------
    function automatic logic [31:0] flush_denorm(logic [31:0] b);
        if (b[30:23] == 8'h00) return {b[31], 31'b0};
        return b;
    endfunction

    function automatic logic [31:0] narrow_f64(logic [63:0] d);
        logic [31:0] sgn;
        int          fe;
        int unsigned mant;
        logic [28:0] rem;
        sgn = {d[63], 31'b0};
        if (d[62:52] == 11'h7FF) begin
            if (d[51:0] == 52'b0) return sgn | 32'h7F80_0000;
            return sgn | 32'h7FC0_0000 | {9'b0, d[51:29]};
        end
        if (d[62:52] == 11'h000) return sgn;
        fe   = int'(d[62:52]) - 1023 + 127;
        mant = {9'b0, d[51:29]};
        rem  = d[28:0];
        // round to nearest, ties to even
        if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && mant[0])) begin
            mant++;
            if (mant == 32'h80_0000) begin
                mant = 0;
                fe++;
            end
        end
        if (fe >= 255) return sgn | 32'h7F80_0000;
        if (fe <= 0) return sgn;
        return sgn | 32'(fe << 23) | mant;
    endfunction

    function automatic logic [63:0] widen_f32(logic [31:0] b);
        logic [63:0] m;
        m = {12'b0, b[22:0], 29'b0};
        if (b[30:23] == 8'h00) return {b[31], 63'b0};
        if (b[30:23] == 8'hFF) return {b[31], 11'h7FF, 52'b0} | m;
        return {b[31], 11'(int'(b[30:23]) - 127 + 1023), 52'b0} | m;
    endfunction

    // Integer to float32 (nearest even), then divide by 2^shift.
    function automatic logic [31:0] int_to_scaled_f32(longint v, int shift);
        logic        sgn;
        longint      mag;
        longint      mant;
        longint      rem;
        longint      half;
        int          msb;
        int          drop;
        if (v == 0) return 32'b0;
        sgn = (v < 0);
        mag = sgn ? -v : v;
        msb = 0;
        for (int i = 0; i < 40; i++) if (mag[i]) msb = i;
        if (msb <= 23) begin
            mant = mag << (23 - msb);
        end else begin
            drop = msb - 23;
            mant = mag >> drop;
            rem  = mag & ((64'd1 << drop) - 1);
            half = 64'd1 << (drop - 1);
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant == 64'd1 << 24) begin
                mant = mant >> 1;
                msb++;
            end
        end
        return {sgn, 8'(msb + 127 - shift), mant[22:0]};
    endfunction

    function automatic logic [31:0] decode_sample(logic [63:0] w, logic [3:0] fmt);
        longint lo32;
        lo32 = longint'($signed(w[31:0]));
        case (fmt)
            pfsc_pkg::FMT_F32:    return flush_denorm(w[31:0]);
            pfsc_pkg::FMT_F64:    return narrow_f64(w);
            pfsc_pkg::FMT_I16:    return int_to_scaled_f32(longint'($signed(w[15:0])), 15);
            pfsc_pkg::FMT_I24:    return int_to_scaled_f32(longint'($signed(w[23:0])), 23);
            pfsc_pkg::FMT_I32:    return int_to_scaled_f32(lo32, 31);
            pfsc_pkg::FMT_I32_16: return int_to_scaled_f32(lo32, 15);
            pfsc_pkg::FMT_I32_18: return int_to_scaled_f32(lo32, 17);
            pfsc_pkg::FMT_I32_20: return int_to_scaled_f32(lo32, 19);
            pfsc_pkg::FMT_I32_24: return int_to_scaled_f32(lo32, 23);
            default:              return 32'b0;
        endcase
    endfunction

    // Product in float32 precision, truncated toward zero.
    function automatic logic [63:0] scale_trunc(real v, real full, logic [63:0] mask);
        real p;
        p = $bitstoreal(widen_f32(narrow_f64($realtobits(v * full))));
        return 64'($signed($rtoi(p))) & mask;
    endfunction

    function automatic logic [63:0] encode_sample(logic [31:0] bits, logic [3:0] fmt);
        logic [31:0] b;
        real         v;
        real         x;
        b = flush_denorm(bits);
        if (fmt == pfsc_pkg::FMT_F32) return {32'b0, b};
        if (fmt == pfsc_pkg::FMT_F64) return widen_f32(b);
        if (fmt > pfsc_pkg::FMT_I32_24) return 64'b0;
        if (b[30:23] == 8'hFF && b[22:0] != 0) return 64'b0;
        v = $bitstoreal(widen_f32(b));
        if (v < -1.0) v = -1.0;
        if (v > 1.0) v = 1.0;
        case (fmt)
            pfsc_pkg::FMT_I16:    return scale_trunc(v, 32767.0, 64'hFFFF);
            pfsc_pkg::FMT_I24:    return scale_trunc(v, 8388607.0, 64'hFF_FFFF);
            pfsc_pkg::FMT_I32: begin
                x = v * 2147483648.0;
                if (x > 2147483647.0) x = 2147483647.0;
                return 64'($signed($rtoi(x))) & 64'hFFFF_FFFF;
            end
            pfsc_pkg::FMT_I32_16: return scale_trunc(v, 32767.0, 64'hFFFF_FFFF);
            pfsc_pkg::FMT_I32_18: return scale_trunc(v, 131071.0, 64'hFFFF_FFFF);
            pfsc_pkg::FMT_I32_20: return scale_trunc(v, 524287.0, 64'hFFFF_FFFF);
            default:              return scale_trunc(v, 8388607.0, 64'hFFFF_FFFF);
        endcase
    endfunction

    function automatic t_conv convert_sample(t_sample s);
        t_conv r;
        r.fout = (s.op == pfsc_pkg::OP_DECODE) ? decode_sample(s.word, dec_fmt) : 32'b0;
        r.enc  = (s.op == pfsc_pkg::OP_ENCODE) ? encode_sample(s.fbits, enc_fmt) : 64'b0;
        r.last = s.last;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generators.
    // ---------------------------------------------------------------
    function automatic logic [31:0] rand_float();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(0, 7))
            0:       ;
            1, 2, 3: b[30:23] = 8'($urandom_range(100, 127));
            4:       b[30:0] = {8'd127, 23'b0};
            5:       b[30:23] = 8'($urandom_range(127, 130));
            6:       b[30:23] = 8'hFF;
            default: b[30:23] = 8'h00;
        endcase
        if ($urandom_range(0, 9) == 0) b[22:0] = 23'b0;
        return b;
    endfunction

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       ;
            1:       w[62:52] = 11'($urandom_range(1023 - 140, 1023 + 140));
            2:       w[62:52] = 11'($urandom_range(0, 1) ? 11'h7FF : 11'h000);
            3:       w[28:0] = {1'b1, 28'b0};
            4:       w[31:0] = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
            default: w[31:0] = 32'($signed(16'($urandom)));
        endcase
        return w;
    endfunction

    function automatic t_sample make_sample(logic op, logic [63:0] w, logic [31:0] f);
        t_sample s;
        s.op    = op;
        s.word  = w;
        s.fbits = f;
        s.last  = 1'($urandom);
        return s;
    endfunction

    // Append one sample to the pending stream.
    task automatic queue_sample(logic op, logic [63:0] w, logic [31:0] f);
        pending_samples = {pending_samples, make_sample(op, w, f)};
    endtask

    // ---------------------------------------------------------------
    // Driver: advance the input beat when accepted or when none is held.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid    <= 1'b0;
            i_op          <= pfsc_pkg::OP_DECODE;
            i_device_word <= '0;
            i_float_in    <= '0;
            i_last_sample <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_conv = {expected_conv, convert_sample(
                    '{i_op, i_device_word, i_float_in, i_last_sample})};
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    t_sample s;
                    s = pending_samples.pop_front();
                    i_op          <= s.op;
                    i_device_word <= s.word;
                    i_float_in    <= s.fbits;
                    i_last_sample <= s.last;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH beat %0d %s: got %h expected %h", beats_checked, what, got, want);
        err_count++;
    endtask

    // Monitor: compare each accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_out_stall <= ($urandom_range(0, 99) < dst_stall_pct);
            if (o_out_valid && !i_out_stall) begin
                if (expected_conv.size() == 0) begin
                    report_mismatch("unexpected beat", o_encoded_word, 64'b0);
                end else begin
                    t_conv e;
                    e = expected_conv.pop_front();
                    if (o_float_out !== e.fout)
                        report_mismatch("float_out", {32'b0, o_float_out}, {32'b0, e.fout});
                    if (o_encoded_word !== e.enc)
                        report_mismatch("encoded_word", o_encoded_word, e.enc);
                    if (o_last_out !== e.last)
                        report_mismatch("last_out", {63'b0, o_last_out}, {63'b0, e.last});
                end
                beats_checked++;
            end
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Wait for the pipe to drain before touching the format registers.
    task automatic wait_idle();
        while (pending_samples.size() > 0 || i_in_valid || expected_conv.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_fmt(logic idx, logic [3:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pfsc_pkg::CFG_DECODE_FMT) dec_fmt = val;
        else enc_fmt = val;
    endtask

    initial begin
        logic [3:0] dfmt;
        logic [3:0] efmt;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = pfsc_pkg::CFG_DECODE_FMT;
        i_cfg_data    = '0;
        dec_fmt       = pfsc_pkg::FMT_RESET;
        enc_fmt       = pfsc_pkg::FMT_RESET;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats at the reset formats (int16 both ways): full-scale
        // ends, zero, clamp, NaN, infinity, denormal flush, ignored high bits.
        queue_sample(pfsc_pkg::OP_DECODE, 64'h0, 32'h0);
        queue_sample(pfsc_pkg::OP_DECODE, 64'h7FFF, 32'hFFFF_FFFF);
        queue_sample(pfsc_pkg::OP_DECODE, 64'h8000, 32'h0);
        queue_sample(pfsc_pkg::OP_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        queue_sample(pfsc_pkg::OP_DECODE, 64'hABCD_0000_1234_0001, 32'h0);
        queue_sample(pfsc_pkg::OP_ENCODE, 64'h0, 32'h3F80_0000);
        queue_sample(pfsc_pkg::OP_ENCODE, 64'h0, 32'hBF80_0000);
        queue_sample(pfsc_pkg::OP_ENCODE, 64'h0, 32'h4000_0000);
        queue_sample(pfsc_pkg::OP_ENCODE, 64'h0, 32'hC000_0000);
        queue_sample(pfsc_pkg::OP_ENCODE, 64'h0, 32'h7FC0_0001);
        queue_sample(pfsc_pkg::OP_ENCODE, 64'h0, 32'hFF80_0000);
        queue_sample(pfsc_pkg::OP_ENCODE, 64'h0, 32'h7F80_0000);
        queue_sample(pfsc_pkg::OP_ENCODE, 64'h0, 32'h8000_0001);
        queue_sample(pfsc_pkg::OP_ENCODE, 64'h0, 32'h3F00_0000);
        queue_sample(pfsc_pkg::OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        queue_sample(pfsc_pkg::OP_ENCODE, 64'h0, 32'h3F7F_FFFF);
        wait_idle();

        // Random phases: sweep every format code in both registers, rotate
        // the idle/stall mix so gaps land on every pipe stage.
        for (int p = 0; p < N_PHASES; p++) begin
            dfmt = 4'(p);
            efmt = 4'((p * 7 + 3) % 16);
            if (p == N_PHASES - 2) begin
                dfmt = 4'd15;
                efmt = pfsc_pkg::FMT_F32;
            end
            if (p == N_PHASES - 1) begin
                dfmt = pfsc_pkg::FMT_F32;
                efmt = 4'd15;
            end
            write_fmt(pfsc_pkg::CFG_DECODE_FMT, dfmt);
            write_fmt(pfsc_pkg::CFG_ENCODE_FMT, efmt);
            case (p % 4)
                0:       begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1:       begin src_idle_pct = 66; dst_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  dst_stall_pct = 66; end
                default: begin src_idle_pct = 33; dst_stall_pct = 33; end
            endcase
            for (int n = 0; n < BEATS_PHASE; n++)
                queue_sample(1'($urandom), rand_word(), rand_float());
            // In phase three, hold the stream half way through and let the pipe empty fully.
            if (p == 3) begin
                while (pending_samples.size() > BEATS_PHASE / 2) @(posedge i_clk);
                src_idle_pct = 100;
                while (i_in_valid || expected_conv.size() > 0) @(posedge i_clk);
                src_idle_pct = 33;
            end
            wait_idle();
        end

        $display("Covered %0d result beats over %0d format phases, all codes in both registers,",
                 beats_checked, N_PHASES + 1);
        $display("with sender gaps and receiver stalls mixed per phase.");
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout waiting for results");
        $display("Some tests failed");
        $finish;
    end

endmodule
